// ----- hw/rtl/suffix_automaton_builder_macros.svh -----
// Assertion macros for the suffix automaton builder.
// Used by the top level only; needs clk and rst in scope.
`ifndef SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked on every clock edge, during reset too.
`define SAB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- hw/rtl/sab_pkg.sv -----
// Package for the suffix automaton builder: payload types and sequencer states.
// No dependencies.
package sab_pkg;
  typedef struct packed {
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [10:0] new_state;
    logic [10:0] new_link;
    logic        clone_made;
    logic [10:0] clone_state;
    logic [11:0] state_count;
    logic        full_res;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_LEN_RD,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LINK_RD,
    ST_Q_RD,
    ST_Q_CHK,
    ST_QL_RD,
    ST_CP_RD,
    ST_CP_WR,
    ST_RD_RD,
    ST_RD_CHK,
    ST_RD_LINK,
    ST_FIN,
    ST_OUT
  } seq_state_t;
endpackage

// ----- hw/rtl/sab_if.sv -----
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given by parameter.
interface sab_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/suffix_automaton_builder.sv -----
// Suffix automaton builder top level: sequencer around three memories.
// Depends on sab_pkg, sab_if and suffix_automaton_builder_macros.svh.
//
//  channel | dir | payload
//  in_ch   | in  | symbol
//  out_ch  | out | new_state new_link clone_made clone_state state_count full_res
//
// One transaction at a time. ST_START reduces a large symbol by ALPHABET until it fits,
// then ST_LEN_RD; each suffix-link step walks ST_WALK_RD, ST_WALK_CHK and ST_LINK_RD
// (not the last); ST_Q_RD, ST_Q_CHK and ST_QL_RD check a hit; ST_FIN and ST_OUT finish.
// A clone copies the row entry by entry through the single transition port and redirects.
// After reset a clearing pass writes every transition entry, one per cycle, in_ch.ready low.
// A result waits in the output register; in_ch.ready stays low until out_ch takes it.
`include "suffix_automaton_builder_macros.svh"
module suffix_automaton_builder #(
  parameter int MAX_LEN    = 1024,
  parameter int MAX_STATES = 2048,
  parameter int ALPHABET   = 256
) (
  input logic clk,
  input logic rst,
  sab_if.sink   in_ch,
  sab_if.source out_ch
);
  localparam int SW = $clog2(MAX_STATES);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int TW = SW + AW;
  localparam int LW = $clog2(MAX_LEN + 1);

  // memories
  logic [LW-1:0] len_mem [MAX_STATES];
  logic [SW-1:0] link_mem [MAX_STATES];
  logic [SW-1:0] tr_mem [2**TW];

  logic [LW-1:0] len_rd;
  logic [SW-1:0] link_rd, tr_rd;
  logic [SW-1:0] len_ra, link_ra;
  logic [TW-1:0] tr_a;
  logic len_we, link_we, tr_we;
  logic [SW-1:0] len_wa, link_wa;
  logic [LW-1:0] len_wd;
  logic [SW-1:0] link_wd, tr_wd;

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    len_rd <= len_mem[len_ra];
  end
  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd <= link_mem[link_ra];
  end
  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_a] <= tr_wd;
    tr_rd <= tr_mem[tr_a];
  end

  sab_pkg::seq_state_t state, state_next;
  logic [TW:0] clr;
  logic [SW-1:0] last, cur, p, q, w, cur_link;
  logic [SW:0] used;
  logic [LW-1:0] tlen;
  logic [7:0] sym;
  logic [AW-1:0] k;
  logic [LW-1:0] plen, lastlen;
  logic cloned;
  sab_pkg::out_item_t res;
  logic out_valid;

  logic full;
  logic sym_big;
  assign full = (tlen >= LW'(MAX_LEN)) || (used + (SW+1)'(2) > (SW+1)'(MAX_STATES));
  assign sym_big = ({1'b0, sym} >= 9'(ALPHABET));

  function automatic logic [TW-1:0] slot(logic [SW-1:0] s, logic [AW-1:0] c);
    return {s, c};
  endfunction

  assign in_ch.ready  = (state == sab_pkg::ST_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sab_pkg::ST_CLEAR:    if (clr == (TW+1)'(2**TW - 1))
                              state_next = sab_pkg::ST_IDLE;
      sab_pkg::ST_IDLE:     if (in_ch.valid && in_ch.ready)
                              state_next = full ? sab_pkg::ST_OUT : sab_pkg::ST_START;
      sab_pkg::ST_START:    state_next = sym_big ? sab_pkg::ST_START : sab_pkg::ST_LEN_RD;
      sab_pkg::ST_LEN_RD:   state_next = sab_pkg::ST_WALK_RD;
      sab_pkg::ST_WALK_RD:  state_next = sab_pkg::ST_WALK_CHK;
      sab_pkg::ST_WALK_CHK: begin
        if (tr_rd != '0) state_next = sab_pkg::ST_Q_RD;
        else if (p == '0) state_next = sab_pkg::ST_FIN;
        else state_next = sab_pkg::ST_LINK_RD;
      end
      sab_pkg::ST_LINK_RD:  state_next = sab_pkg::ST_WALK_RD;
      sab_pkg::ST_Q_RD:     state_next = sab_pkg::ST_Q_CHK;
      sab_pkg::ST_Q_CHK:    state_next = sab_pkg::ST_QL_RD;
      sab_pkg::ST_QL_RD:    state_next = (plen + LW'(1) == len_rd) ? sab_pkg::ST_FIN
                                                                   : sab_pkg::ST_CP_RD;
      sab_pkg::ST_CP_RD:    state_next = sab_pkg::ST_CP_WR;
      sab_pkg::ST_CP_WR:    state_next = (k == AW'(ALPHABET-1)) ? sab_pkg::ST_RD_RD
                                                                : sab_pkg::ST_CP_RD;
      sab_pkg::ST_RD_RD:    state_next = sab_pkg::ST_RD_CHK;
      sab_pkg::ST_RD_CHK: begin
        if (tr_rd != q || p == '0) state_next = sab_pkg::ST_FIN;
        else state_next = sab_pkg::ST_RD_LINK;
      end
      sab_pkg::ST_RD_LINK:  state_next = sab_pkg::ST_RD_RD;
      sab_pkg::ST_FIN:      state_next = sab_pkg::ST_OUT;
      sab_pkg::ST_OUT:      state_next = sab_pkg::ST_IDLE;
      default:              state_next = sab_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    len_we = 1'b0; len_wa = cur; len_wd = lastlen + LW'(1); len_ra = last;
    link_we = 1'b0; link_wa = cur; link_wd = '0; link_ra = p;
    tr_we = 1'b0; tr_wd = cur; tr_a = slot(p, sym[AW-1:0]);
    unique case (state)
      sab_pkg::ST_CLEAR: begin
        tr_we = 1'b1; tr_wd = '0; tr_a = clr[TW-1:0];
        // root length is zero
        len_we = 1'b1; len_wa = '0; len_wd = '0;
      end
      sab_pkg::ST_START:   len_ra = last;
      sab_pkg::ST_LEN_RD:  len_ra = p;
      sab_pkg::ST_WALK_CHK: begin
        tr_we = (tr_rd == '0);
        link_ra = p;
        len_ra = p;
      end
      sab_pkg::ST_Q_RD:    len_ra = p;
      sab_pkg::ST_Q_CHK:   len_ra = tr_rd;
      sab_pkg::ST_QL_RD:   link_ra = q;
      sab_pkg::ST_CP_RD: begin
        tr_a = slot(q, k);
        link_ra = q;
      end
      sab_pkg::ST_CP_WR: begin
        tr_we = 1'b1; tr_a = slot(w, k); tr_wd = tr_rd;
        if (k == '0) begin
          len_we = 1'b1; len_wa = w; len_wd = plen + LW'(1);
          link_we = 1'b1; link_wa = w; link_wd = link_rd;
        end
      end
      sab_pkg::ST_RD_CHK: begin
        tr_we = (tr_rd == q); tr_wd = w;
      end
      sab_pkg::ST_FIN: begin
        len_we = 1'b1;
        link_we = cloned; link_wa = q; link_wd = w;
      end
      sab_pkg::ST_OUT: begin
        link_we = !res.full_res; link_wa = cur; link_wd = cur_link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sab_pkg::ST_CLEAR;
      clr <= '0;
      last <= '0;
      used <= (SW+1)'(1);
      tlen <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        sab_pkg::ST_CLEAR: clr <= clr + (TW+1)'(1);
        sab_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          sym <= in_ch.data.symbol;
          p <= last;
          cloned <= 1'b0;
          cur_link <= '0;
          res <= '{new_state: 11'd0, new_link: 11'd0, clone_made: 1'b0,
                   clone_state: 11'd0, state_count: 12'(used), full_res: full};
          if (!full) begin
            cur <= used[SW-1:0];
            used <= used + (SW+1)'(1);
          end
        end
        // reduce the symbol into the alphabet
        sab_pkg::ST_START: if (sym_big) sym <= 8'({1'b0, sym} - 9'(ALPHABET));
        sab_pkg::ST_LEN_RD: lastlen <= len_rd;
        sab_pkg::ST_WALK_CHK: if (tr_rd != '0) q <= tr_rd;
        sab_pkg::ST_LINK_RD: p <= link_rd;
        sab_pkg::ST_Q_CHK: plen <= len_rd;
        sab_pkg::ST_QL_RD: begin
          res.new_link <= 11'(q);
          cur_link <= q;
          k <= '0;
          if (plen + LW'(1) != len_rd) begin
            w <= used[SW-1:0];
            used <= used + (SW+1)'(1);
            cloned <= 1'b1;
          end
        end
        sab_pkg::ST_CP_WR: k <= k + AW'(1);
        sab_pkg::ST_RD_LINK: p <= link_rd;
        sab_pkg::ST_FIN: begin
          last <= cur;
          tlen <= tlen + LW'(1);
          res.new_state <= 11'(cur);
          if (cloned) begin
            res.new_link <= 11'(w);
            cur_link <= w;
          end
          res.clone_made <= cloned;
          res.clone_state <= cloned ? 11'(w) : 11'd0;
          res.state_count <= 12'(used);
        end
        sab_pkg::ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  `SAB_ASSERT(a_no_accept_busy, (state != sab_pkg::ST_IDLE) |-> !in_ch.ready, "accept while busy")
  `SAB_ASSERT(a_out_hold, (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)), "result dropped")
  `SAB_ASSERT(a_used_bound, 1'b1 |-> (used <= (SW+1)'(MAX_STATES)), "state count overflow")
endmodule

// ----- sim/suffix_automaton_builder_checker.sv -----
// Checker for the suffix automaton builder: watches both channels, predicts
// each result from its own copy of the automaton and compares in order.
// Depends on sab_pkg.
`timescale 1ns / 100ps
module suffix_automaton_builder_checker #(
  parameter int TEXT_MAX   = 1024,
  parameter int STATE_MAX  = 2048,
  parameter int SYMBOL_MAX = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  sab_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  sab_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 pending
);
  int unsigned state_len[STATE_MAX];
  int unsigned state_link[STATE_MAX];
  int unsigned edge_to[STATE_MAX * SYMBOL_MAX];
  int unsigned tail_state = 0;
  int unsigned n_states = 1;
  int unsigned text_len = 0;
  sab_pkg::out_item_t expected_results[$];

  initial begin
    mismatches = 0;
    foreach (state_len[i]) begin
      state_len[i] = 0;
      state_link[i] = 0;
    end
    foreach (edge_to[i]) edge_to[i] = 0;
  end

  assign pending = expected_results.size();

  // Extend the automaton by one symbol and return the expected result.
  function automatic sab_pkg::out_item_t extend_automaton(logic [7:0] sym_in);
    sab_pkg::out_item_t res;
    int unsigned sym, cur, p, q, w, steps;
    bit          hit;
    sym = sym_in % SYMBOL_MAX;
    res = '0;
    hit = 0;
    w = 0;
    if (text_len >= TEXT_MAX || n_states + 2 > STATE_MAX) begin
      res.state_count = n_states[11:0];
      res.full_res = 1'b1;
      return res;
    end
    cur = n_states;
    n_states++;
    state_len[cur] = state_len[tail_state] + 1;
    state_link[cur] = 0;
    p = tail_state;
    for (steps = 0; steps < STATE_MAX; steps++) begin
      if (edge_to[p * SYMBOL_MAX + sym] != 0) begin
        hit = 1;
        break;
      end
      edge_to[p * SYMBOL_MAX + sym] = cur;
      if (p == 0) break;
      p = state_link[p];
    end
    if (hit) begin
      q = edge_to[p * SYMBOL_MAX + sym];
      if (state_len[p] + 1 == state_len[q]) begin
        state_link[cur] = q;
      end else begin
        w = n_states;
        n_states++;
        res.clone_made = 1'b1;
        state_len[w] = state_len[p] + 1;
        state_link[w] = state_link[q];
        for (int a = 0; a < SYMBOL_MAX; a++)
          edge_to[w * SYMBOL_MAX + a] = edge_to[q * SYMBOL_MAX + a];
        // Redirect the chain of transitions that led to q.
        for (steps = 0; steps < STATE_MAX; steps++) begin
          if (edge_to[p * SYMBOL_MAX + sym] != q) break;
          edge_to[p * SYMBOL_MAX + sym] = w;
          if (p == 0) break;
          p = state_link[p];
        end
        state_link[q] = w;
        state_link[cur] = w;
      end
    end
    tail_state = cur;
    text_len++;
    res.new_state = cur[10:0];
    res.new_link = state_link[cur][10:0];
    res.clone_state = res.clone_made ? w[10:0] : 11'd0;
    res.state_count = n_states[11:0];
    return res;
  endfunction

  always @(posedge clk) begin
    sab_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(extend_automaton(in_data.symbol));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.new_state !== want.new_state || out_data.new_link !== want.new_link ||
              out_data.clone_made !== want.clone_made ||
              out_data.clone_state !== want.clone_state ||
              out_data.state_count !== want.state_count ||
              out_data.full_res !== want.full_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
    end
  end
endmodule

// ----- sim/suffix_automaton_builder_test.sv -----
// Testbench top for the suffix automaton builder: clock, reset, symbol
// stimulus with idling phases, result stalls and the verdict.
// Depends on sab_pkg, sab_if, the block and suffix_automaton_builder_checker.
`timescale 1ns / 100ps
module suffix_automaton_builder_test;

  localparam int  N_DIRECTED = 22;
  localparam int  N_RANDOM   = 1530;
  localparam int  HOLD_OFF   = 400;
  localparam longint CYCLE_LIMIT = 6000000;

  logic   clk;
  logic   rst;
  int     mismatches;
  int     pending;
  int     phase = 0;
  int     sent = 0;
  longint cycles = 0;
  bit     hold_done = 0;

  sab_if #(.payload_t(sab_pkg::in_item_t))  in_ch (clk);
  sab_if #(.payload_t(sab_pkg::out_item_t)) out_ch (clk);

  suffix_automaton_builder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  suffix_automaton_builder_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int send_idle_pct(int ph);
    return (ph == 2) ? 69 : (ph == 4) ? 29 : 0;
  endfunction

  function automatic int recv_stall_pct(int ph);
    return (ph == 3) ? 69 : (ph == 4) ? 29 : 0;
  endfunction

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    // Mostly tiny alphabets so repeats, long walks and clones are common.
    if (r < 45) return 8'h61 + 8'($urandom_range(0, 1));
    if (r < 75) return 8'($urandom_range(0, 3)) ^ 8'hF0;
    if (r < 90) return 8'h0F ^ 8'($urandom_range(0, 7));
    return 8'($urandom());
  endfunction

  // Result side: random stalls per phase, one long hold-off with input busy.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && phase == 2 && sent > N_DIRECTED + 500) begin
        hold_done = 1;
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct(phase));
    end
  end

  initial begin
    logic [7:0] directed[N_DIRECTED] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h00, 8'h00,
                                         8'h01, 8'h01, 8'h00, 8'h01, 8'h02, 8'h01, 8'h02,
                                         8'h02, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00,
                                         8'h01};
    int total;
    int wait_cycles;
    total = N_DIRECTED + N_RANDOM;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    while (sent < total) begin
      phase = (sent < N_DIRECTED) ? 0 : 1 + (sent - N_DIRECTED) * 4 / N_RANDOM;
      if ($urandom_range(0, 99) < send_idle_pct(phase)) begin
        in_ch.valid = 1'b0;
        in_ch.data = sab_pkg::in_item_t'($urandom());
        @(negedge clk);
      end else begin
        in_ch.valid = 1'b1;
        in_ch.data.symbol = (sent < N_DIRECTED) ? directed[sent] : pick_symbol();
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
        @(negedge clk);
        if (sent == total) in_ch.valid = 1'b0;
      end
    end
    in_ch.valid = 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (600) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/sab_pkg.sv
hw/rtl/sab_if.sv
hw/rtl/suffix_automaton_builder.sv
sim/suffix_automaton_builder_checker.sv
sim/suffix_automaton_builder_test.sv
